### hdl/voxel_visible_face_extract_unit_assert.svh
// Assertion macros shared by the RTL.
`ifndef VOXEL_VISIBLE_FACE_EXTRACT_UNIT_ASSERT_SVH
`define VOXEL_VISIBLE_FACE_EXTRACT_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define VVFE_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vvfe: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define VVFE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vvfe: next-cycle check failed");

`endif

### hdl/vvfe_pkg.sv
`default_nettype none

package vvfe_pkg;

	localparam int GRID_SIDE_DEF = 16;
	localparam int POS_W         = 4;
	localparam int TYPE_W        = 7;
	localparam int DIR_W         = 3;
	localparam int IDX_W         = 12;
	localparam int CNT_W         = 13;
	localparam int NBR_W         = 7;
	localparam int NUM_DIR       = 6;
	localparam int CMD_DEPTH     = 2;
	localparam int RES_DEPTH     = 4;

	localparam logic [CNT_W-1:0] CNT_MAX = 13'd8191;
	localparam logic [IDX_W-1:0] IDX_MAX = 12'd4095;

	localparam logic [DIR_W-1:0] DIR_BACK   = 3'd0;
	localparam logic [DIR_W-1:0] DIR_FRONT  = 3'd1;
	localparam logic [DIR_W-1:0] DIR_BOTTOM = 3'd2;
	localparam logic [DIR_W-1:0] DIR_TOP    = 3'd3;
	localparam logic [DIR_W-1:0] DIR_LEFT   = 3'd4;
	localparam logic [DIR_W-1:0] DIR_RIGHT  = 3'd5;

	typedef enum logic [1:0] {
		ACT_WRITE   = 2'd0,
		ACT_SCAN    = 2'd1,
		ACT_RESTART = 2'd2
	} action_t;

	typedef struct packed {
		action_t            op;
		logic [POS_W-1:0]   x;
		logic [POS_W-1:0]   y;
		logic [POS_W-1:0]   z;
		logic [TYPE_W-1:0]  vtype;
	} cmd_t;

	typedef struct packed {
		logic [DIR_W-1:0]   dir;
		logic [POS_W-1:0]   x;
		logic [POS_W-1:0]   y;
		logic [POS_W-1:0]   z;
		logic [TYPE_W-1:0]  vtype;
		logic [IDX_W-1:0]   index;
		logic               last_face;
	} face_t;

	typedef struct packed {
		logic [NBR_W-1:0] x;
		logic [NBR_W-1:0] y;
		logic [NBR_W-1:0] z;
	} npos_t;

	typedef enum logic [1:0] {
		B_CLEAR,
		B_IDLE,
		B_READ,
		B_EMIT
	} back_state_t;

	typedef struct packed {
		logic clearing;
		logic scanning;
	} back_status_t;

	function automatic npos_t own_pos(logic [POS_W-1:0] x, logic [POS_W-1:0] y,
			logic [POS_W-1:0] z);
		npos_t p;
		p.x = NBR_W'(x);
		p.y = NBR_W'(y);
		p.z = NBR_W'(z);
		return p;
	endfunction

	// Step below zero wraps high and lands outside the grid.
	function automatic npos_t nbr_pos(logic [DIR_W-1:0] dir, logic [POS_W-1:0] x,
			logic [POS_W-1:0] y, logic [POS_W-1:0] z);
		npos_t p;
		p = own_pos(x, y, z);
		unique case (dir)
			DIR_BACK:   p.z = p.z - NBR_W'(1);
			DIR_FRONT:  p.z = p.z + NBR_W'(1);
			DIR_BOTTOM: p.y = p.y - NBR_W'(1);
			DIR_TOP:    p.y = p.y + NBR_W'(1);
			DIR_LEFT:   p.x = p.x - NBR_W'(1);
			DIR_RIGHT:  p.x = p.x + NBR_W'(1);
			default:    p = own_pos(x, y, z);
		endcase
		return p;
	endfunction

endpackage

`default_nettype wire

### hdl/vvfe_fifo.sv
`default_nettype none

module vvfe_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  empty
);

	localparam int PW = $clog2(DEPTH);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [PW:0]      count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == (PW+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (PW+1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (PW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

### hdl/vvfe_front.sv
`default_nettype none

module vvfe_front #(
	parameter int GRID_SIDE = vvfe_pkg::GRID_SIDE_DEF
) (
	input  wire logic                         push,
	output logic                              full,
	input  wire logic [1:0]                   action,
	input  wire logic [vvfe_pkg::POS_W-1:0]   pos_x,
	input  wire logic [vvfe_pkg::POS_W-1:0]   pos_y,
	input  wire logic [vvfe_pkg::POS_W-1:0]   pos_z,
	input  wire logic [vvfe_pkg::TYPE_W-1:0]  voxel_type,
	input  wire vvfe_pkg::back_status_t       back_status,
	input  wire logic                         cmd_full,
	output logic                              cmd_push,
	output vvfe_pkg::cmd_t                    cmd
);

	localparam logic [vvfe_pkg::NBR_W-1:0] SIDE = vvfe_pkg::NBR_W'(GRID_SIDE);

	vvfe_pkg::npos_t p;
	logic            in_grid;
	logic            keep;

	assign full    = cmd_full || back_status.clearing;
	assign p       = vvfe_pkg::own_pos(pos_x, pos_y, pos_z);
	assign in_grid = (p.x < SIDE) && (p.y < SIDE) && (p.z < SIDE);

	always_comb begin
		unique case (action)
			vvfe_pkg::ACT_WRITE,
			vvfe_pkg::ACT_SCAN:    keep = in_grid;
			vvfe_pkg::ACT_RESTART: keep = 1'b1;
			default:               keep = 1'b0;
		endcase
	end

	assign cmd_push  = push && !full && keep;
	assign cmd.op    = vvfe_pkg::action_t'(action);
	assign cmd.x     = pos_x;
	assign cmd.y     = pos_y;
	assign cmd.z     = pos_z;
	assign cmd.vtype = voxel_type;

endmodule

`default_nettype wire

### hdl/vvfe_back.sv
`default_nettype none

module vvfe_back #(
	parameter int GRID_SIDE = vvfe_pkg::GRID_SIDE_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire vvfe_pkg::cmd_t         cmd,
	input  wire logic                   cmd_empty,
	output logic                        cmd_pop,
	output vvfe_pkg::face_t             res,
	input  wire logic                   res_full,
	output logic                        res_push,
	output vvfe_pkg::back_status_t      status
);

	localparam int CW    = $clog2(GRID_SIDE);
	localparam int AW    = 3 * CW;
	localparam int CELLS = 1 << AW;
	localparam int NB    = vvfe_pkg::NBR_W;
	localparam int ND    = vvfe_pkg::NUM_DIR;
	localparam int TW    = vvfe_pkg::TYPE_W;
	localparam int CNW   = vvfe_pkg::CNT_W;
	localparam int DW    = vvfe_pkg::DIR_W;

	localparam logic [NB-1:0] SIDE           = NB'(GRID_SIDE);
	localparam logic [2:0]    STEP_OWN       = 3'd0;
	localparam logic [2:0]    STEP_OWN_DATA  = 3'd1;
	localparam logic [2:0]    STEP_FIRST_NBR = 3'd2;
	localparam logic [2:0]    STEP_LAST      = 3'd7;

	function automatic logic [AW-1:0] cell_addr(vvfe_pkg::npos_t p);
		return {p.z[CW-1:0], p.y[CW-1:0], p.x[CW-1:0]};
	endfunction

	logic [TW-1:0]  mem [CELLS];
	logic [TW-1:0]  rd_data_q;

	vvfe_pkg::back_state_t state_q, state_d;
	logic [AW-1:0]  clr_q;
	vvfe_pkg::cmd_t cmd_q;
	logic [2:0]     step_q;
	logic           oob_q;
	logic [TW-1:0]  own_q;
	logic [ND-1:0]  mask_q;
	logic [CNW-1:0] cnt_q [ND];

	vvfe_pkg::npos_t rd_pos;
	logic            rd_oob;
	logic            rd_en;
	logic [AW-1:0]   rd_addr;
	logic            mem_we;
	logic [AW-1:0]   mem_wa;
	logic [TW-1:0]   mem_wd;
	logic            arr_empty;
	logic [ND-1:0]   mask_nx;
	logic [DW-1:0]   pick_dir;
	logic [ND-1:0]   pick_sel;
	logic [ND-1:0]   remain;
	logic            load_cmd;
	logic            ctr_clear;
	logic            ctr_inc;
	logic [CNW-1:0]  pick_cnt;

	always_comb begin
		if (step_q == STEP_OWN) begin
			rd_pos = vvfe_pkg::own_pos(cmd_q.x, cmd_q.y, cmd_q.z);
		end else begin
			rd_pos = vvfe_pkg::nbr_pos(DW'(step_q - 3'd1), cmd_q.x, cmd_q.y, cmd_q.z);
		end
	end

	assign rd_oob    = (rd_pos.x >= SIDE) || (rd_pos.y >= SIDE) || (rd_pos.z >= SIDE);
	assign rd_addr   = cell_addr(rd_pos);
	assign arr_empty = oob_q || (rd_data_q == '0);

	always_comb begin
		mask_nx = mask_q;
		for (int i = 0; i < ND; i++) begin
			if (step_q == 3'(i + 2)) begin
				mask_nx[i] = arr_empty;
			end
		end
	end

	always_comb begin
		pick_dir = '0;
		for (int i = ND - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				pick_dir = DW'(i);
			end
		end
		pick_sel = '0;
		pick_sel[pick_dir] = 1'b1;
		remain   = mask_q & ~pick_sel;
	end

	assign pick_cnt      = cnt_q[pick_dir];
	assign res.dir       = pick_dir;
	assign res.x         = cmd_q.x;
	assign res.y         = cmd_q.y;
	assign res.z         = cmd_q.z;
	assign res.vtype     = own_q;
	assign res.index     = (pick_cnt > CNW'(vvfe_pkg::IDX_MAX)) ? vvfe_pkg::IDX_MAX
		: pick_cnt[vvfe_pkg::IDX_W-1:0];
	assign res.last_face = (remain == '0);

	assign status.clearing = (state_q == vvfe_pkg::B_CLEAR);
	assign status.scanning = (state_q == vvfe_pkg::B_READ) || (state_q == vvfe_pkg::B_EMIT);

	always_comb begin
		state_d   = state_q;
		cmd_pop   = 1'b0;
		mem_we    = 1'b0;
		mem_wa    = clr_q;
		mem_wd    = '0;
		rd_en     = 1'b0;
		res_push  = 1'b0;
		load_cmd  = 1'b0;
		ctr_clear = 1'b0;
		ctr_inc   = 1'b0;
		unique case (state_q)
			vvfe_pkg::B_CLEAR: begin
				mem_we = 1'b1;
				if (clr_q == {AW{1'b1}}) begin
					state_d = vvfe_pkg::B_IDLE;
				end
			end
			vvfe_pkg::B_IDLE: begin
				if (!cmd_empty) begin
					cmd_pop = 1'b1;
					unique case (cmd.op)
						vvfe_pkg::ACT_WRITE: begin
							mem_we = 1'b1;
							mem_wa = cell_addr(vvfe_pkg::own_pos(cmd.x, cmd.y, cmd.z));
							mem_wd = cmd.vtype;
						end
						vvfe_pkg::ACT_SCAN: begin
							load_cmd = 1'b1;
							state_d  = vvfe_pkg::B_READ;
						end
						vvfe_pkg::ACT_RESTART: begin
							ctr_clear = 1'b1;
						end
						default: ;
					endcase
				end
			end
			vvfe_pkg::B_READ: begin
				rd_en = (step_q != STEP_LAST) && !rd_oob;
				if ((step_q == STEP_OWN_DATA) && (rd_data_q == '0)) begin
					state_d = vvfe_pkg::B_IDLE;
				end else if (step_q == STEP_LAST) begin
					state_d = (mask_nx != '0) ? vvfe_pkg::B_EMIT : vvfe_pkg::B_IDLE;
				end
			end
			vvfe_pkg::B_EMIT: begin
				if (!res_full) begin
					res_push = 1'b1;
					ctr_inc  = 1'b1;
					if (remain == '0) begin
						state_d = vvfe_pkg::B_IDLE;
					end
				end
			end
			default: state_d = vvfe_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vvfe_pkg::B_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			step_q <= '0;
			mask_q <= '0;
			for (int i = 0; i < ND; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			if (status.clearing) begin
				clr_q <= clr_q + AW'(1);
			end
			if (load_cmd) begin
				step_q <= STEP_OWN;
				mask_q <= '0;
			end else if (state_q == vvfe_pkg::B_READ) begin
				step_q <= step_q + 3'd1;
				if (step_q >= STEP_FIRST_NBR) begin
					mask_q <= mask_nx;
				end
			end else if (res_push) begin
				mask_q <= remain;
			end
			if (ctr_clear) begin
				for (int i = 0; i < ND; i++) begin
					cnt_q[i] <= '0;
				end
			end else if (ctr_inc && (pick_cnt != vvfe_pkg::CNT_MAX)) begin
				cnt_q[pick_dir] <= pick_cnt + CNW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_cmd) begin
			cmd_q <= cmd;
		end
		if (state_q == vvfe_pkg::B_READ) begin
			oob_q <= rd_oob;
			if (step_q == STEP_OWN_DATA) begin
				own_q <= rd_data_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

### hdl/voxel_visible_face_extract_unit.sv
// Voxel visible-face extractor.
// Input queue: drive action, pos_x/y/z and voxel_type with push; the item transfers
// on a clock edge with push high and full low. Write stores a type, restart clears
// the six direction counters, scan emits one face record per open side of a solid
// cell. Unused actions and positions outside the grid are dropped at the input.
// Result queue: a record waits on the face ports while empty is low and transfers
// on an edge with pop high. last_face marks the final record of a scan.
// A write or restart is done as the back end takes it from the queue; a scan takes
// the command, reads the cell and its six neighbors through the voxel memory read
// port and then pushes its face records, stalling while the result queue is full.
// A scan of an empty cell ends once the cell's own read returns.
// A 2-entry command queue separates the input from the back end and a 4-entry
// result queue buffers records; full rises whenever the command queue fills, and
// while pop is low it holds once both queues fill.
// After reset the voxel memory is swept to empty, one cell per cycle: 4096
// cells at a side of 16, 2^(3*ceil(log2 side)) in general. full stays high
// during the sweep. Counters and queues clear at once.
`default_nettype none

`include "voxel_visible_face_extract_unit_assert.svh"

module voxel_visible_face_extract_unit #(
	parameter int GRID_SIDE = vvfe_pkg::GRID_SIDE_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         push,
	output logic                              full,
	input  wire logic [1:0]                   action,
	input  wire logic [vvfe_pkg::POS_W-1:0]   pos_x,
	input  wire logic [vvfe_pkg::POS_W-1:0]   pos_y,
	input  wire logic [vvfe_pkg::POS_W-1:0]   pos_z,
	input  wire logic [vvfe_pkg::TYPE_W-1:0]  voxel_type,
	output logic                              empty,
	input  wire logic                         pop,
	output logic [vvfe_pkg::DIR_W-1:0]        face_dir,
	output logic [vvfe_pkg::POS_W-1:0]        face_x,
	output logic [vvfe_pkg::POS_W-1:0]        face_y,
	output logic [vvfe_pkg::POS_W-1:0]        face_z,
	output logic [vvfe_pkg::TYPE_W-1:0]       face_type,
	output logic [vvfe_pkg::IDX_W-1:0]        face_index,
	output logic                              last_face
);

	localparam int CMD_W = $bits(vvfe_pkg::cmd_t);
	localparam int RES_W = $bits(vvfe_pkg::face_t);

	vvfe_pkg::back_status_t back_status;
	vvfe_pkg::cmd_t         cmd_in;
	vvfe_pkg::cmd_t         cmd_head;
	vvfe_pkg::face_t        res_face;
	vvfe_pkg::face_t        res_head;
	logic [CMD_W-1:0]       cmd_rdata;
	logic [RES_W-1:0]       res_rdata;
	logic                   cmd_push;
	logic                   cmd_full;
	logic                   cmd_pop;
	logic                   cmd_empty;
	logic                   res_push;
	logic                   res_full;

	vvfe_front #(
		.GRID_SIDE (GRID_SIDE)
	) u_front (
		.push        (push),
		.full        (full),
		.action      (action),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pos_z       (pos_z),
		.voxel_type  (voxel_type),
		.back_status (back_status),
		.cmd_full    (cmd_full),
		.cmd_push    (cmd_push),
		.cmd         (cmd_in)
	);

	vvfe_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (vvfe_pkg::CMD_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_rdata),
		.empty  (cmd_empty)
	);

	assign cmd_head = vvfe_pkg::cmd_t'(cmd_rdata);

	vvfe_back #(
		.GRID_SIDE (GRID_SIDE)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_head),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.res       (res_face),
		.res_full  (res_full),
		.res_push  (res_push),
		.status    (back_status)
	);

	vvfe_fifo #(
		.WIDTH (RES_W),
		.DEPTH (vvfe_pkg::RES_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_face),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_rdata),
		.empty  (empty)
	);

	assign res_head   = vvfe_pkg::face_t'(res_rdata);
	assign face_dir   = res_head.dir;
	assign face_x     = res_head.x;
	assign face_y     = res_head.y;
	assign face_z     = res_head.z;
	assign face_type  = res_head.vtype;
	assign face_index = res_head.index;
	assign last_face  = res_head.last_face;

	`VVFE_ASSERT_IMPL(a_res_no_overflow, res_push, !res_full)
	`VVFE_ASSERT_IMPL(a_cmd_no_overflow, cmd_push, !cmd_full)
	`VVFE_ASSERT_IMPL(a_sweep_holds_cmds, back_status.clearing, !cmd_pop && full)
	`VVFE_ASSERT_NEXT(a_last_ends_scan, res_push && res_face.last_face, !back_status.scanning)

endmodule

`default_nettype wire
